// ----- rtl/vertex_rotate_scale_translate_defines.svh -----
// Assertion macros for the vertex transform block.
`ifndef VERTEX_ROTATE_SCALE_TRANSLATE_DEFINES_SVH
`define VERTEX_ROTATE_SCALE_TRANSLATE_DEFINES_SVH
`ifndef SYNTHESIS
`define VRST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vrst: same-cycle check failed");
`define VRST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vrst: next-cycle check failed");
`else
`define VRST_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define VRST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/vrst_pkg.sv -----
`default_nettype none

package vrst_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 3'd5;

    localparam logic [47:0] ROW_X_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROW_Z_RESET = 48'h4000_0000_0000;
    localparam logic [15:0] SCALE_RESET = 16'h1000;

    localparam logic ORDER_RST = 1'b0;  // rotate, scale, translate
    localparam logic ORDER_RTS = 1'b1;  // rotate, translate, scale

    localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] out_pos_x;
        logic signed [15:0] out_pos_y;
        logic signed [15:0] out_pos_z;
        logic signed [15:0] out_norm_x;
        logic signed [15:0] out_norm_y;
        logic signed [15:0] out_norm_z;
    } out_word_t;

    // Per-stage advance strobes, upstream to downstream.
    typedef struct packed {
        logic mul;
        logic sum;
        logic pre;
        logic scl;
        logic fin;
    } stage_adv_t;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < 40'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vrst_rotate.sv -----
`default_nettype none

// Two stages: nine products, then row sums rounded and saturated.
module vrst_rotate (
    input  wire logic                   aclk,
    input  wire vrst_pkg::stage_adv_t   adv,
    input  wire logic [2:0][47:0]       rows,
    input  wire logic [47:0]            vec_in,
    output logic [47:0]                 vec_out
);

    localparam logic signed [33:0] ROT_HALF = 34'sd8192;

    logic signed [31:0] prod_reg [3][3];
    logic [47:0]        rot_reg;
    logic [47:0]        rot_next;
    logic signed [33:0] row_sum [3];
    logic signed [19:0] row_shift [3];

    always_ff @(posedge aclk) begin
        if (adv.mul) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= $signed(rows[r][16*c +: 16])
                                    * $signed(vec_in[16*c +: 16]);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = 34'(prod_reg[r][0]) + 34'(prod_reg[r][1])
                       + 34'(prod_reg[r][2]) + ROT_HALF;
            row_shift[r] = 20'(row_sum[r] >>> 14);
            rot_next[16*r +: 16] = vrst_pkg::sat16(40'(row_shift[r]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.sum) begin
            rot_reg <= rot_next;
        end
    end

    assign vec_out = rot_reg;

endmodule

`default_nettype wire

// ----- rtl/vrst_post.sv -----
`default_nettype none

// Three stages on the position: pre-translate, scale product, round and
// post-translate. The normal rides alongside.
module vrst_post (
    input  wire logic                   aclk,
    input  wire vrst_pkg::stage_adv_t   adv,
    input  wire logic [47:0]            rot_pos,
    input  wire logic [47:0]            rot_norm,
    input  wire logic [47:0]            translation,
    input  wire logic [15:0]            scale,
    input  wire logic                   order_mode,
    output vrst_pkg::out_word_t         out_word
);

    localparam logic signed [32:0] SCL_HALF = 33'sd2048;

    logic [47:0]        pre_reg;
    logic [47:0]        pre_next;
    logic [47:0]        norm_pre_reg;
    logic signed [32:0] scl_reg [3];
    logic [47:0]        norm_scl_reg;
    logic [47:0]        fin_next;
    logic signed [32:0] rnd_sum [3];
    logic signed [15:0] scaled [3];
    vrst_pkg::out_word_t out_reg;

    // Translate first only in rotate-translate-scale order.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (order_mode == vrst_pkg::ORDER_RTS) begin
                pre_next[16*k +: 16] = vrst_pkg::sat16(
                    40'($signed(rot_pos[16*k +: 16]))
                    + 40'($signed(translation[16*k +: 16])));
            end else begin
                pre_next[16*k +: 16] = rot_pos[16*k +: 16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.pre) begin
            pre_reg      <= pre_next;
            norm_pre_reg <= rot_norm;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.scl) begin
            for (int k = 0; k < 3; k++) begin
                scl_reg[k] <= $signed({1'b0, scale}) * $signed(pre_reg[16*k +: 16]);
            end
            norm_scl_reg <= norm_pre_reg;
        end
    end

    // Round the scale product, then translate in rotate-scale-translate order.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd_sum[k] = scl_reg[k] + SCL_HALF;
            scaled[k]  = vrst_pkg::sat16(40'(rnd_sum[k] >>> 12));
            if (order_mode == vrst_pkg::ORDER_RST) begin
                fin_next[16*k +: 16] = vrst_pkg::sat16(
                    40'(scaled[k]) + 40'($signed(translation[16*k +: 16])));
            end else begin
                fin_next[16*k +: 16] = scaled[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.fin) begin
            out_reg.out_pos_x  <= fin_next[15:0];
            out_reg.out_pos_y  <= fin_next[31:16];
            out_reg.out_pos_z  <= fin_next[47:32];
            out_reg.out_norm_x <= norm_scl_reg[15:0];
            out_reg.out_norm_y <= norm_scl_reg[31:16];
            out_reg.out_norm_z <= norm_scl_reg[47:32];
        end
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

// ----- rtl/vertex_rotate_scale_translate.sv -----
// Stages from input acceptance to m_valid: multiply, row sum, pre-translate,
// scale multiply, round/translate into the output register.
// Throughput: one vertex per cycle; each stage advances on its own, so bubbles
// close up and a stalled output only blocks the input once the pipe is full.
// Reset (aresetn low, synchronous): all stage valid bits clear, registers take
// identity matrix, zero translation, scale 1.0 and rotate-scale-translate.
`default_nettype none

`include "vertex_rotate_scale_translate_defines.svh"

module vertex_rotate_scale_translate (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [vrst_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [vrst_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // vertex input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire vrst_pkg::in_word_t                 s_data,
    // transformed vertex output
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output vrst_pkg::out_word_t                     m_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [47:0] row_x_reg;
    logic [47:0] row_y_reg;
    logic [47:0] row_z_reg;
    logic [47:0] translate_reg;
    logic [15:0] scale_reg;
    logic        order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg     <= vrst_pkg::ROW_X_RESET;
            row_y_reg     <= vrst_pkg::ROW_Y_RESET;
            row_z_reg     <= vrst_pkg::ROW_Z_RESET;
            translate_reg <= '0;
            scale_reg     <= vrst_pkg::SCALE_RESET;
            order_reg     <= vrst_pkg::ORDER_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                vrst_pkg::REG_ROW_X:     row_x_reg     <= cfg_wdata;
                vrst_pkg::REG_ROW_Y:     row_y_reg     <= cfg_wdata;
                vrst_pkg::REG_ROW_Z:     row_z_reg     <= cfg_wdata;
                vrst_pkg::REG_TRANSLATE: translate_reg <= cfg_wdata;
                vrst_pkg::REG_SCALE:     scale_reg     <= cfg_wdata[15:0];
                vrst_pkg::REG_ORDER:     order_reg     <= cfg_wdata[0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage valid bits and advance chain
    // ---------------------------------------------------------------
    // A stage advances when it is empty or the stage after it advances.
    // This lets a word move into a hole even while the output waits.
    logic v_mul_reg, v_sum_reg, v_pre_reg, v_scl_reg, v_fin_reg;
    logic v_mul_next, v_sum_next, v_pre_next, v_scl_next, v_fin_next;
    vrst_pkg::stage_adv_t adv;

    always_comb begin
        adv.fin = !v_fin_reg || m_ready;
        adv.scl = !v_scl_reg || adv.fin;
        adv.pre = !v_pre_reg || adv.scl;
        adv.sum = !v_sum_reg || adv.pre;
        adv.mul = !v_mul_reg || adv.sum;
    end

    assign s_ready = adv.mul;

    // Each stage takes the valid bit of its upstream neighbor when it advances.
    always_comb begin
        v_mul_next = adv.mul ? s_valid   : v_mul_reg;
        v_sum_next = adv.sum ? v_mul_reg : v_sum_reg;
        v_pre_next = adv.pre ? v_sum_reg : v_pre_reg;
        v_scl_next = adv.scl ? v_pre_reg : v_scl_reg;
        v_fin_next = adv.fin ? v_scl_reg : v_fin_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_mul_reg <= 1'b0;
            v_sum_reg <= 1'b0;
            v_pre_reg <= 1'b0;
            v_scl_reg <= 1'b0;
            v_fin_reg <= 1'b0;
        end else begin
            v_mul_reg <= v_mul_next;
            v_sum_reg <= v_sum_next;
            v_pre_reg <= v_pre_next;
            v_scl_reg <= v_scl_next;
            v_fin_reg <= v_fin_next;
        end
    end

    assign m_valid = v_fin_reg;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic [2:0][47:0] rows;
    logic [47:0]      pos_vec;
    logic [47:0]      norm_vec;
    logic [47:0]      rot_pos;
    logic [47:0]      rot_norm;

    assign rows     = {row_z_reg, row_y_reg, row_x_reg};
    assign pos_vec  = {s_data.pos_z, s_data.pos_y, s_data.pos_x};
    assign norm_vec = {s_data.norm_z, s_data.norm_y, s_data.norm_x};

    // Position and normal each get their own rotation unit.
    vrst_rotate u_rot_pos (
        .aclk    (aclk),
        .adv     (adv),
        .rows    (rows),
        .vec_in  (pos_vec),
        .vec_out (rot_pos)
    );

    vrst_rotate u_rot_norm (
        .aclk    (aclk),
        .adv     (adv),
        .rows    (rows),
        .vec_in  (norm_vec),
        .vec_out (rot_norm)
    );

    // Scale and translate the position in the configured order.
    vrst_post u_post (
        .aclk        (aclk),
        .adv         (adv),
        .rot_pos     (rot_pos),
        .rot_norm    (rot_norm),
        .translation (translate_reg),
        .scale       (scale_reg),
        .order_mode  (order_reg),
        .out_word    (m_data)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `VRST_ASSERT_NEXT(a_accept_fills_mul, aclk, aresetn, s_valid && s_ready, v_mul_reg)
    `VRST_ASSERT_NEXT(a_sum_holds, aclk, aresetn, v_sum_reg && !adv.sum, v_sum_reg && $stable(rot_pos))
    `VRST_ASSERT_IMPL(a_scl_blocked, aclk, aresetn, v_scl_reg && !adv.fin, !adv.scl)

endmodule

`default_nettype wire

// ----- bench/vrst_result_checker.sv -----
`default_nettype none

module vrst_result_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [vrst_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [vrst_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire vrst_pkg::in_word_t              s_data,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire vrst_pkg::out_word_t             m_data,
    output int                                   mismatches,
    output int                                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the transform registers.
    logic [47:0] row_x;
    logic [47:0] row_y;
    logic [47:0] row_z;
    logic [47:0] offsets;
    logic [15:0] scale;
    logic        order;

    vrst_pkg::out_word_t expected_vertices[$];

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) begin
            return vrst_pkg::SAT_MAX;
        end else if (v < -32768) begin
            return vrst_pkg::SAT_MIN;
        end
        return v[15:0];
    endfunction

    // Add half an LSB, then floor-shift.
    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] lane16(input logic [47:0] word48, input int k);
        return word48[16*k +: 16];
    endfunction

    function automatic logic signed [15:0] dot_row(input logic [47:0] row,
                                                   input logic signed [15:0] a,
                                                   input logic signed [15:0] b,
                                                   input logic signed [15:0] c);
        longint acc;
        acc = longint'(lane16(row, 0)) * a + longint'(lane16(row, 1)) * b
            + longint'(lane16(row, 2)) * c;
        return clamp16(round_down_shift(acc, 14));
    endfunction

    function automatic logic signed [15:0] apply_scale(input logic signed [15:0] v);
        return clamp16(round_down_shift(longint'(scale) * v, 12));
    endfunction

    function automatic logic signed [15:0] add_offset(input logic signed [15:0] v,
                                                      input logic signed [15:0] t);
        return clamp16(longint'(v) + longint'(t));
    endfunction

    function automatic vrst_pkg::out_word_t transform_vertex(input vrst_pkg::in_word_t v);
        logic signed [15:0] rot [3];
        logic signed [15:0] placed [3];
        vrst_pkg::out_word_t r;
        rot[0] = dot_row(row_x, v.pos_x, v.pos_y, v.pos_z);
        rot[1] = dot_row(row_y, v.pos_x, v.pos_y, v.pos_z);
        rot[2] = dot_row(row_z, v.pos_x, v.pos_y, v.pos_z);
        for (int k = 0; k < 3; k++) begin
            if (order == vrst_pkg::ORDER_RST) begin
                placed[k] = add_offset(apply_scale(rot[k]), lane16(offsets, k));
            end else begin
                placed[k] = apply_scale(add_offset(rot[k], lane16(offsets, k)));
            end
        end
        r.out_pos_x  = placed[0];
        r.out_pos_y  = placed[1];
        r.out_pos_z  = placed[2];
        // Normals get the rotation only.
        r.out_norm_x = dot_row(row_x, v.norm_x, v.norm_y, v.norm_z);
        r.out_norm_y = dot_row(row_y, v.norm_x, v.norm_y, v.norm_z);
        r.out_norm_z = dot_row(row_z, v.norm_x, v.norm_y, v.norm_z);
        return r;
    endfunction

    always @(posedge aclk) begin
        vrst_pkg::out_word_t want;
        if (!aresetn) begin
            row_x   = vrst_pkg::ROW_X_RESET;
            row_y   = vrst_pkg::ROW_Y_RESET;
            row_z   = vrst_pkg::ROW_Z_RESET;
            offsets = '0;
            scale   = vrst_pkg::SCALE_RESET;
            order   = vrst_pkg::ORDER_RST;
            expected_vertices.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    vrst_pkg::REG_ROW_X:     row_x   = cfg_wdata[47:0];
                    vrst_pkg::REG_ROW_Y:     row_y   = cfg_wdata[47:0];
                    vrst_pkg::REG_ROW_Z:     row_z   = cfg_wdata[47:0];
                    vrst_pkg::REG_TRANSLATE: offsets = cfg_wdata[47:0];
                    vrst_pkg::REG_SCALE:     scale   = cfg_wdata[15:0];
                    vrst_pkg::REG_ORDER:     order   = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_vertices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%t: output word with none pending: %h", $realtime, m_data);
                    end
                end else begin
                    want = expected_vertices.pop_front();
                    if (m_data.out_pos_x !== want.out_pos_x
                        || m_data.out_pos_y !== want.out_pos_y
                        || m_data.out_pos_z !== want.out_pos_z
                        || m_data.out_norm_x !== want.out_norm_x
                        || m_data.out_norm_y !== want.out_norm_y
                        || m_data.out_norm_z !== want.out_norm_z) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%t: mismatch exp pos %0d %0d %0d nrm %0d %0d %0d",
                                     $realtime, want.out_pos_x, want.out_pos_y,
                                     want.out_pos_z, want.out_norm_x, want.out_norm_y,
                                     want.out_norm_z);
                            $display("%t:          got pos %0d %0d %0d nrm %0d %0d %0d",
                                     $realtime, m_data.out_pos_x, m_data.out_pos_y,
                                     m_data.out_pos_z, m_data.out_norm_x,
                                     m_data.out_norm_y, m_data.out_norm_z);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_vertices = {expected_vertices, transform_vertex(s_data)};
            end
        end
        outstanding = expected_vertices.size();
    end

endmodule

`default_nettype wire

// ----- bench/tb_vertex_rotate_scale_translate.sv -----
`default_nettype none

module tb_vertex_rotate_scale_translate;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the end of the register map; writes there must be dropped.
    localparam logic [vrst_pkg::CFG_IDX_W-1:0] REG_PAST_END  = 3'd6;
    localparam logic [vrst_pkg::CFG_IDX_W-1:0] REG_LAST_SLOT = 3'd7;

    // Abort after this many cycles without any word moving on either side.
    localparam int STALL_LIMIT = 4000;
    // Pipeline is 5 deep; give it a margin before the verdict.
    localparam int TAIL_CYCLES = 20;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [vrst_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [vrst_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    vrst_pkg::in_word_t              s_data;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    vrst_pkg::out_word_t             m_data;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 12;
    int recv_stall_pct = 64;
    int quiet_cycles   = 0;

    vertex_rotate_scale_translate u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    vrst_result_checker u_result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 12 ns clock: 6 ns high, 6 ns low.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver back-pressure: drop ready at random, re-rolled every cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles in which no word is accepted on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[vertex_rotate_scale_translate] ERROR");
                $finish;
            end
        end
    end

    // All tasks below are entered and left at a falling edge.

    // Pulse one register write, then drop the enable and wait before returning.
    task automatic write_reg(input logic [vrst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Load a full transform; junk goes in the unused upper bits of the
    // narrow registers so that masking gets exercised.
    task automatic program_transform(input logic [47:0] rx, input logic [47:0] ry,
                                     input logic [47:0] rz, input logic [47:0] offs,
                                     input logic [15:0] scl, input logic mode);
        write_reg(vrst_pkg::REG_ROW_X, rx);
        write_reg(vrst_pkg::REG_ROW_Y, ry);
        write_reg(vrst_pkg::REG_ROW_Z, rz);
        write_reg(vrst_pkg::REG_TRANSLATE, offs);
        write_reg(vrst_pkg::REG_SCALE, {32'($urandom), scl});
        write_reg(vrst_pkg::REG_ORDER, {47'({$urandom, $urandom}), mode});
    endtask

    // Present one vertex word, with random idle cycles ahead of it, and hold
    // it until the block takes it. Valid stays high on return.
    task automatic send_vertex(input vrst_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic wait_pipeline_empty();
        s_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic vrst_pkg::in_word_t uniform_vertex(input logic [15:0] v);
        return '{v, v, v, v, v, v};
    endfunction

    // Coefficient mix: anything, unit-circle range, corner values, tiny.
    function automatic logic [15:0] rand_coef();
        logic [15:0] corners [5] = '{16'h8000, 16'h7fff, 16'h4000, 16'hc000, 16'h0000};
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(32768)) - 16'd16384;
            2:       return corners[$urandom_range(4)];
            default: return 16'($urandom_range(2048)) - 16'd1024;
        endcase
    endfunction

    function automatic logic [47:0] rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // Component mix: half full-range, the rest moderate, corner or tiny values so results are not all clipped.
    function automatic logic [15:0] rand_comp();
        logic [15:0] corners [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6, 7:       return 16'($urandom_range(8192)) - 16'd4096;
            8:             return corners[$urandom_range(3)];
            default:       return 16'($urandom_range(6)) - 16'd3;
        endcase
    endfunction

    function automatic vrst_pkg::in_word_t rand_vertex();
        return '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp()};
    endfunction

    task automatic program_random_transform();
        logic [15:0] scl;
        logic [47:0] offs;
        case ($urandom_range(4))
            0:       scl = vrst_pkg::SCALE_RESET;
            1:       scl = 16'($urandom);
            2:       scl = 16'($urandom_range(8192));
            3:       scl = 16'h0000;
            default: scl = 16'hffff;
        endcase
        if ($urandom_range(1) == 0) begin
            offs = 48'({$urandom, $urandom});
        end else begin
            offs = {16'($urandom_range(4096)) - 16'd2048,
                    16'($urandom_range(4096)) - 16'd2048,
                    16'($urandom_range(4096)) - 16'd2048};
        end
        program_transform(rand_row(), rand_row(), rand_row(), offs, scl,
                          $urandom_range(1) ? vrst_pkg::ORDER_RTS : vrst_pkg::ORDER_RST);
        // Now and then poke the unmapped slots; they must change nothing.
        if ($urandom_range(3) == 0) begin
            write_reg(REG_PAST_END, 48'({$urandom, $urandom}));
            write_reg(REG_LAST_SLOT, 48'({$urandom, $urandom}));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;

        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: identity transform straight out of reset.
        send_vertex(uniform_vertex(16'h0000));
        send_vertex(uniform_vertex(16'h7fff));
        send_vertex(uniform_vertex(16'h8000));
        send_vertex('{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
        send_vertex('{16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff});

        // Half-scale diagonal: odd inputs land exactly on the rounding midpoint.
        wait_pipeline_empty();
        program_transform(48'h0000_0000_2000, 48'h0000_2000_0000, 48'h2000_0000_0000,
                          48'h0, 16'h0800, vrst_pkg::ORDER_RST);
        send_vertex('{16'h0001, 16'hffff, 16'h0003, 16'hfffd, 16'h0001, 16'hffff});
        send_vertex('{16'h0003, 16'hfffd, 16'h0001, 16'h0001, 16'hffff, 16'h0003});
        send_vertex(uniform_vertex(16'h7fff));

        // Most negative coefficients, full-scale gain and offsets: saturate.
        wait_pipeline_empty();
        program_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                          {3{16'h7fff}}, 16'hffff, vrst_pkg::ORDER_RTS);
        send_vertex(uniform_vertex(16'h7fff));
        send_vertex(uniform_vertex(16'h8000));
        send_vertex('{16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h0001});
        wait_pipeline_empty();
        write_reg(vrst_pkg::REG_ORDER, {47'h0, vrst_pkg::ORDER_RST});
        send_vertex(uniform_vertex(16'h7fff));
        send_vertex('{16'h0001, 16'h0000, 16'hffff, 16'h8000, 16'h0000, 16'h7fff});

        // Largest positive coefficients, zero gain, most negative offsets.
        wait_pipeline_empty();
        program_transform({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
                          {3{16'h8000}}, 16'h0000, vrst_pkg::ORDER_RTS);
        send_vertex(uniform_vertex(16'h7fff));
        send_vertex(uniform_vertex(16'h8000));

        // Writes past the end of the map: expect the same transform as before.
        wait_pipeline_empty();
        write_reg(REG_PAST_END, {48{1'b1}});
        write_reg(REG_LAST_SLOT, 48'h1234_5678_9abc);
        send_vertex('{16'h1000, 16'hf000, 16'h0800, 16'h0000, 16'h1000, 16'hf800});
        send_vertex(rand_vertex());

        // Random: three idling profiles, five transforms each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 64;
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 12;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (5) begin
                wait_pipeline_empty();
                program_random_transform();
                repeat (83) begin
                    send_vertex(rand_vertex());
                end
            end
        end

        // Drain, then give any stray output word time to show up.
        wait_pipeline_empty();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("[vertex_rotate_scale_translate] OK");
        end else begin
            $display("[vertex_rotate_scale_translate] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/vrst_pkg.sv
rtl/vrst_rotate.sv
rtl/vrst_post.sv
rtl/vertex_rotate_scale_translate.sv
bench/vrst_result_checker.sv
bench/tb_vertex_rotate_scale_translate.sv
